// File: hdl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg
// Types and constants shared by the tuple field decompressor modules.
// ----------------------------------------------------------------------------
package tfd_pkg;

    localparam int ATTR_W    = 6;   // attribute index as seen on the ports
    localparam int CNT_W     = 7;   // attribute count register
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 8;
    localparam int CAP_W     = 9;   // holds the largest table depth itself

    localparam logic [BYTE_W-1:0] BLANK = 8'd32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ATTR_W-1:0] entry_index;
        logic              entry_is_char;
        logic [LEN_W-1:0]  entry_length;
        logic [BYTE_W-1:0] source_byte;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [LEN_W-1:0]  repeat_count;
        logic [ATTR_W-1:0] attribute_number;
        logic              record_end;
    } t_out_item;

    typedef struct packed {
        logic             is_char;
        logic [LEN_W-1:0] length;
    } t_fmt_entry;

    // format table access from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [ATTR_W-1:0] wr_index;
        t_fmt_entry        wr_entry;
        logic              rd_en;
        logic [CNT_W-1:0]  rd_attr;
    } t_tbl_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT,
        ST_SCAN,
        ST_PUT
    } t_state;

endpackage

// File: hdl/tfd_table.sv
// ----------------------------------------------------------------------------
// tfd_table
// Format table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tfd_table #(
    parameter int MAX_ATTRIBUTES = 64
) (
    input  logic                  i_clk,
    input  tfd_pkg::t_tbl_req     i_req,
    output tfd_pkg::t_fmt_entry   o_rd
);

    localparam int MemAw = (MAX_ATTRIBUTES > 1) ? $clog2(MAX_ATTRIBUTES) : 1;
    localparam logic [tfd_pkg::CAP_W-1:0] MaxAttrW = tfd_pkg::CAP_W'(MAX_ATTRIBUTES);

    tfd_pkg::t_fmt_entry r_mem [MAX_ATTRIBUTES];
    tfd_pkg::t_fmt_entry r_rd_data;
    logic                r_rd_oob;

    logic [tfd_pkg::CAP_W-1:0] w_wr_wide;
    logic [tfd_pkg::CAP_W-1:0] w_rd_wide;

    assign w_wr_wide = {{(tfd_pkg::CAP_W - tfd_pkg::ATTR_W){1'b0}}, i_req.wr_index};
    assign w_rd_wide = {{(tfd_pkg::CAP_W - tfd_pkg::CNT_W){1'b0}}, i_req.rd_attr};

    // loads past the table depth are dropped
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && (w_wr_wide < MaxAttrW)) begin
            r_mem[w_wr_wide[MemAw-1:0]] <= i_req.wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[w_rd_wide[MemAw-1:0]];
            r_rd_oob  <= !(w_rd_wide < MaxAttrW);
        end
    end

    // attributes beyond the table read as zero length, numeric
    assign o_rd = r_rd_oob ? '0 : r_rd_data;

endmodule

// File: hdl/tfd_ctrl.sv
// ----------------------------------------------------------------------------
// tfd_ctrl
// Record sequencer: attribute position, bytes left, zero-length skip,
// record-end look-ahead and the output register.
// ----------------------------------------------------------------------------
module tfd_ctrl #(
    parameter int MAX_ATTRIBUTES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tfd_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tfd_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [tfd_pkg::CNT_W-1:0]     i_cfg_data,
    output tfd_pkg::t_tbl_req             o_tbl_req,
    input  tfd_pkg::t_fmt_entry           i_tbl_rd
);

    localparam logic [tfd_pkg::CAP_W-1:0] MaxAttrW = tfd_pkg::CAP_W'(MAX_ATTRIBUTES);

    tfd_pkg::t_state r_state, n_state;

    logic [tfd_pkg::CNT_W-1:0]  r_count, n_count;
    logic [tfd_pkg::CNT_W-1:0]  r_cur, n_cur;
    logic [tfd_pkg::LEN_W-1:0]  r_bl, n_bl;
    logic                       r_loaded, n_loaded;
    logic                       r_char, n_char;
    logic [tfd_pkg::CNT_W-1:0]  r_k, n_k;
    logic [tfd_pkg::BYTE_W-1:0] r_byte, n_byte;
    logic [tfd_pkg::BYTE_W-1:0] r_pb, n_pb;
    logic [tfd_pkg::LEN_W-1:0]  r_prep, n_prep;
    logic [tfd_pkg::ATTR_W-1:0] r_pattr, n_pattr;
    logic                       r_pend, n_pend;
    logic                       r_out_valid, n_out_valid;
    tfd_pkg::t_out_item         r_out_data, n_out_data;

    logic [tfd_pkg::CNT_W-1:0]  w_n;
    logic [tfd_pkg::BYTE_W-1:0] w_eb;
    logic                       w_pad;
    logic [tfd_pkg::BYTE_W-1:0] w_ob;
    logic [tfd_pkg::LEN_W-1:0]  w_rep;
    logic [tfd_pkg::LEN_W-1:0]  w_bl;
    logic                       w_out_free;
    logic                       w_in_acc;
    logic                       w_wrap;
    logic [tfd_pkg::CNT_W:0]    w_cur_inc;
    logic                       w_cur_wraps;
    logic [tfd_pkg::CNT_W-1:0]  w_cur_next;
    logic [tfd_pkg::CNT_W:0]    w_k_inc;
    logic                       w_k_end;

    // effective attribute count: zero acts as one, clipped to the table depth
    always_comb begin
        if (r_count == '0) begin
            w_n = tfd_pkg::CNT_W'(1);
        end else if ({{(tfd_pkg::CAP_W - tfd_pkg::CNT_W){1'b0}}, r_count} > MaxAttrW) begin
            w_n = MaxAttrW[tfd_pkg::CNT_W-1:0];
        end else begin
            w_n = r_count;
        end
    end

    assign w_eb  = (r_state == tfd_pkg::ST_IDLE) ? i_in_data.source_byte : r_byte;
    assign w_pad = r_char && (w_eb == '0);
    assign w_ob  = w_pad ? tfd_pkg::BLANK : w_eb;
    assign w_rep = w_pad ? r_bl : tfd_pkg::LEN_W'(1);
    assign w_bl  = w_pad ? '0 : (r_bl - tfd_pkg::LEN_W'(1));

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != tfd_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == tfd_pkg::ST_IDLE);

    assign w_wrap      = (r_cur >= w_n);
    assign w_cur_inc   = {1'b0, r_cur} + (tfd_pkg::CNT_W + 1)'(1);
    assign w_cur_wraps = (w_cur_inc >= {1'b0, w_n});
    assign w_cur_next  = w_cur_wraps ? '0 : w_cur_inc[tfd_pkg::CNT_W-1:0];
    assign w_k_inc     = {1'b0, r_k} + (tfd_pkg::CNT_W + 1)'(1);
    assign w_k_end     = (w_k_inc >= {1'b0, w_n});

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cur       = r_cur;
        n_bl        = r_bl;
        n_loaded    = r_loaded;
        n_char      = r_char;
        n_k         = r_k;
        n_byte      = r_byte;
        n_pb        = r_pb;
        n_prep      = r_prep;
        n_pattr     = r_pattr;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;

        o_tbl_req.wr_en            = 1'b0;
        o_tbl_req.wr_index         = i_in_data.entry_index;
        o_tbl_req.wr_entry.is_char = i_in_data.entry_is_char;
        o_tbl_req.wr_entry.length  = i_in_data.entry_length;
        o_tbl_req.rd_en            = 1'b0;
        o_tbl_req.rd_attr          = r_cur;

        case (r_state)
            tfd_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.command == tfd_pkg::CMD_LOAD) begin
                        o_tbl_req.wr_en = 1'b1;
                        // char flag of the open field follows the table
                        if ({{(tfd_pkg::CNT_W - tfd_pkg::ATTR_W){1'b0}},
                             i_in_data.entry_index} == r_cur) begin
                            n_char = i_in_data.entry_is_char;
                        end
                    end else begin
                        n_byte = i_in_data.source_byte;
                        if (r_loaded && !w_wrap) begin
                            // mid-field byte goes straight out when the slot is free
                            if ((w_bl != '0) && w_out_free) begin
                                n_out_valid = 1'b1;
                                n_out_data  = '{out_byte: w_ob, repeat_count: w_rep,
                                                attribute_number: r_cur[tfd_pkg::ATTR_W-1:0],
                                                record_end: 1'b0};
                                n_bl        = w_bl;
                            end else begin
                                n_state = tfd_pkg::ST_EMIT;
                            end
                        end else begin
                            n_cur             = w_wrap ? '0 : r_cur;
                            n_loaded          = 1'b0;
                            n_k               = '0;
                            o_tbl_req.rd_en   = 1'b1;
                            o_tbl_req.rd_attr = w_wrap ? '0 : r_cur;
                            n_state           = tfd_pkg::ST_FETCH;
                        end
                    end
                end
            end

            tfd_pkg::ST_FETCH: begin
                if (i_tbl_rd.length != '0) begin
                    n_bl     = i_tbl_rd.length;
                    n_char   = i_tbl_rd.is_char;
                    n_loaded = 1'b1;
                    n_state  = tfd_pkg::ST_EMIT;
                end else if (r_k == w_n) begin
                    // whole record has zero length: byte is dropped
                    n_loaded = 1'b0;
                    n_state  = tfd_pkg::ST_IDLE;
                end else begin
                    n_cur             = w_cur_next;
                    n_k               = w_k_inc[tfd_pkg::CNT_W-1:0];
                    o_tbl_req.rd_en   = 1'b1;
                    o_tbl_req.rd_attr = w_cur_next;
                end
            end

            tfd_pkg::ST_EMIT: begin
                if (w_bl != '0) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '{out_byte: w_ob, repeat_count: w_rep,
                                        attribute_number: r_cur[tfd_pkg::ATTR_W-1:0],
                                        record_end: 1'b0};
                        n_bl        = w_bl;
                        n_state     = tfd_pkg::ST_IDLE;
                    end
                end else begin
                    n_bl     = '0;
                    n_loaded = 1'b0;
                    n_pb     = w_ob;
                    n_prep   = w_rep;
                    n_pattr  = r_cur[tfd_pkg::ATTR_W-1:0];
                    n_cur    = w_cur_next;
                    if (w_cur_wraps) begin
                        n_pend  = 1'b1;
                        n_state = tfd_pkg::ST_PUT;
                    end else begin
                        // look ahead for a later nonzero field
                        n_k               = w_cur_next;
                        o_tbl_req.rd_en   = 1'b1;
                        o_tbl_req.rd_attr = w_cur_next;
                        n_state           = tfd_pkg::ST_SCAN;
                    end
                end
            end

            tfd_pkg::ST_SCAN: begin
                if (i_tbl_rd.length != '0) begin
                    n_pend  = 1'b0;
                    n_state = tfd_pkg::ST_PUT;
                end else if (w_k_end) begin
                    n_pend  = 1'b1;
                    n_state = tfd_pkg::ST_PUT;
                end else begin
                    n_k               = w_k_inc[tfd_pkg::CNT_W-1:0];
                    o_tbl_req.rd_en   = 1'b1;
                    o_tbl_req.rd_attr = w_k_inc[tfd_pkg::CNT_W-1:0];
                end
            end

            tfd_pkg::ST_PUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '{out_byte: r_pb, repeat_count: r_prep,
                                    attribute_number: r_pattr, record_end: r_pend};
                    n_state     = tfd_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tfd_pkg::ST_IDLE;
            end
        endcase

        // count write restarts the record
        if (i_cfg_we) begin
            n_count  = i_cfg_data;
            n_cur    = '0;
            n_bl     = '0;
            n_loaded = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= tfd_pkg::CNT_W'(1);
            r_cur       <= '0;
            r_bl        <= '0;
            r_loaded    <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_cur       <= n_cur;
            r_bl        <= n_bl;
            r_loaded    <= n_loaded;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_byte     <= n_byte;
        r_pb       <= n_pb;
        r_prep     <= n_prep;
        r_pattr    <= n_pattr;
        r_pend     <= n_pend;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: hdl/tuple_field_decompressor.sv
// ----------------------------------------------------------------------------
// tuple_field_decompressor
// Expands a compressed record one source byte at a time under a loaded
// per-attribute format table (length, character flag).
//
//   channel   direction  handshake              payload
//   in        input      i_in_valid/o_in_stall  i_in_data  (t_in_item)
//   out       output     o_out_valid/i_out_stall o_out_data (t_out_item)
//   cfg       input      i_cfg_we               i_cfg_data (attribute count)
//
// A table load, or a byte inside an open field with the output free, is
// handled while idle. Any other byte adds table reads (the new field's
// entry and each skipped zero-length one; each later entry up to the first
// nonzero one in the record-end scan), the emit state, and the put state
// when it closes the field; a byte dropped by an all-zero record has its
// reads only. Synchronous active-low reset; table undefined until loaded.
// ----------------------------------------------------------------------------
module tuple_field_decompressor #(
    parameter int MAX_ATTRIBUTES = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  tfd_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output tfd_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_we,
    input  logic [tfd_pkg::CNT_W-1:0] i_cfg_data
);

    tfd_pkg::t_tbl_req   w_tbl_req;
    tfd_pkg::t_fmt_entry w_tbl_rd;

    tfd_ctrl #(
        .MAX_ATTRIBUTES(MAX_ATTRIBUTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_tbl_req   (w_tbl_req),
        .i_tbl_rd    (w_tbl_rd)
    );

    tfd_table #(
        .MAX_ATTRIBUTES(MAX_ATTRIBUTES)
    ) u_table (
        .i_clk (i_clk),
        .i_req (w_tbl_req),
        .o_rd  (w_tbl_rd)
    );

endmodule

// File: hdl/tfd_checker.sv
// ----------------------------------------------------------------------------
// tfd_checker
// Port-level checks for the tuple field decompressor, bound to the top level.
// ----------------------------------------------------------------------------
module tfd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input tfd_pkg::t_in_item         i_in_data,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input tfd_pkg::t_out_item        o_out_data
);

    // output transaction holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");

    a_rep_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.repeat_count != '0))
        else $error("zero repeat count");

    // runs longer than one are blank padding only
    a_run_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.repeat_count > 8'd1) |->
            (o_out_data.out_byte == tfd_pkg::BLANK))
        else $error("run of non-blank bytes");

    // a table load never yields an output transaction
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.command == tfd_pkg::CMD_LOAD) &&
            !o_out_valid |=> !o_out_valid)
        else $error("output after table load");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind tuple_field_decompressor tfd_checker u_tfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: sim/tuple_field_decompressor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tuple_field_decompressor_test
// Self-checking bench for the tuple field decompressor. Loads the format
// table, runs a directed record sequence, then random records under several
// attribute counts. Every accepted input transaction goes through an
// in-bench expansion model. Output transactions are compared field by field
// in order. Random gaps are applied on the input side and random stalls on
// the output side.
// ----------------------------------------------------------------------------
module tuple_field_decompressor_test;

    localparam int TABLE_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 200;  // covers a full zero-length scan

    // length profiles for table loads
    localparam int LEN_TINY  = 0;
    localparam int LEN_SHORT = 1;
    localparam int LEN_MIXED = 2;

    class record_expansion_check;
        tfd_pkg::t_fmt_entry fmt[TABLE_DEPTH];
        int unsigned         count_reg;
        int unsigned         cur_attr;
        int unsigned         bytes_left;
        bit                  field_open;
        tfd_pkg::t_out_item  pending_outputs[$];
        int                  errors;

        function new();
            count_reg  = 1;
            cur_attr   = 0;
            bytes_left = 0;
            field_open = 0;
            errors     = 0;
            foreach (fmt[i]) fmt[i] = '0;
        endfunction

        function void set_count(logic [tfd_pkg::CNT_W-1:0] v);
            count_reg  = 32'(v);
            cur_attr   = 0;
            bytes_left = 0;
            field_open = 0;
        endfunction

        function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, what, exp_v, act_v);
        endfunction

        function void absorb_transaction(tfd_pkg::t_in_item it);
            int unsigned                n;
            int unsigned                a;
            int unsigned                k;
            logic [tfd_pkg::BYTE_W-1:0] ob;
            logic [tfd_pkg::LEN_W-1:0]  rep;
            bit                         rec_end;
            tfd_pkg::t_out_item         res;
            if (it.command == tfd_pkg::CMD_LOAD) begin
                fmt[it.entry_index] = {it.entry_is_char, it.entry_length};
                return;
            end
            n = (count_reg < 1) ? 1 : (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
            if (cur_attr >= n) begin
                cur_attr   = 0;
                field_open = 0;
            end
            if (!field_open) begin
                bytes_left = 32'(fmt[cur_attr].length);
                field_open = 1;
            end
            // skip zero-length attributes, at most one full record
            for (k = 0; k < n && bytes_left == 0; k++) begin
                cur_attr++;
                if (cur_attr >= n) cur_attr = 0;
                bytes_left = 32'(fmt[cur_attr].length);
            end
            if (bytes_left == 0) begin
                field_open = 0;   // every length zero: byte dropped
                return;
            end
            a = cur_attr;
            if (fmt[a].is_char && it.source_byte == '0) begin
                ob         = tfd_pkg::BLANK;
                rep        = tfd_pkg::LEN_W'(bytes_left);
                bytes_left = 0;
            end else begin
                ob         = it.source_byte;
                rep        = 1;
                bytes_left--;
            end
            rec_end = 0;
            if (bytes_left == 0) begin
                rec_end = 1;
                for (k = a + 1; k < n; k++)
                    if (fmt[k].length != 0) rec_end = 0;
                cur_attr   = (a + 1 >= n) ? 0 : a + 1;
                field_open = 0;
            end
            res.out_byte         = ob;
            res.repeat_count     = rep;
            res.attribute_number = tfd_pkg::ATTR_W'(a);
            res.record_end       = rec_end;
            pending_outputs.push_back(res);
        endfunction

        function void match_output(tfd_pkg::t_out_item got);
            tfd_pkg::t_out_item exp_item;
            if (pending_outputs.size() == 0) begin
                errors++;
                $display("%0t: unexpected output: expected none, actual %h",
                         $time, got);
                return;
            end
            exp_item = pending_outputs.pop_front();
            if (got.out_byte !== exp_item.out_byte)
                report("out_byte", 32'(exp_item.out_byte), 32'(got.out_byte));
            if (got.repeat_count !== exp_item.repeat_count)
                report("repeat_count", 32'(exp_item.repeat_count),
                       32'(got.repeat_count));
            if (got.attribute_number !== exp_item.attribute_number)
                report("attribute_number", 32'(exp_item.attribute_number),
                       32'(got.attribute_number));
            if (got.record_end !== exp_item.record_end)
                report("record_end", 32'(exp_item.record_end), 32'(got.record_end));
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    tfd_pkg::t_in_item           i_in_data = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    tfd_pkg::t_out_item          o_out_data;
    logic                        i_cfg_we = 1'b0;
    logic [tfd_pkg::CNT_W-1:0]   i_cfg_data = '0;

    record_expansion_check sb;
    bit          tx_gaps = 1'b1;
    bit          rx_gaps = 1'b1;
    int unsigned hold_cycles = 0;

    tuple_field_decompressor #(
        .MAX_ATTRIBUTES(TABLE_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // output side: check each transaction, then stall for a random spell
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                sb.match_output(o_out_data);
                hold_cycles = rx_gaps ? $urandom_range(0, 7) : 0;
            end else if (hold_cycles > 0) begin
                hold_cycles--;
            end
            i_out_stall <= (hold_cycles != 0);
        end
    end

    function automatic int draw_length(int mode);
        int unsigned r;
        case (mode)
            LEN_TINY: begin
                return $urandom_range(0, 3);
            end
            LEN_SHORT: begin
                return ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            end
            default: begin
                r = $urandom_range(0, 19);
                if (r == 0) return $urandom_range(200, 255);
                if (r < 6) return 0;
                return $urandom_range(1, 6);
            end
        endcase
    endfunction

    function automatic tfd_pkg::t_in_item load_item(int idx, int is_char, int len);
        tfd_pkg::t_in_item it;
        it.command       = tfd_pkg::CMD_LOAD;
        it.entry_index   = tfd_pkg::ATTR_W'(idx);
        it.entry_is_char = 1'(is_char);
        it.entry_length  = tfd_pkg::LEN_W'(len);
        it.source_byte   = tfd_pkg::BYTE_W'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic tfd_pkg::t_in_item byte_item(logic [tfd_pkg::BYTE_W-1:0] b);
        tfd_pkg::t_in_item it;
        it.command       = tfd_pkg::CMD_BYTE;
        it.entry_index   = tfd_pkg::ATTR_W'($urandom_range(0, 63));
        it.entry_is_char = 1'($urandom_range(0, 1));
        it.entry_length  = tfd_pkg::LEN_W'($urandom_range(0, 255));
        it.source_byte   = b;
        return it;
    endfunction

    // entered right after a rising edge; returns at the accepting edge
    task automatic send_item(tfd_pkg::t_in_item it);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.absorb_transaction(it);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_outputs.size() != 0) @(posedge i_clk);
    endtask

    task automatic configure_count(logic [tfd_pkg::CNT_W-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_count(v);
    endtask

    initial begin
        int          cnt;
        int          n;
        int          mode;
        int          idx;
        logic [7:0]  b;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every table entry gets written before any byte goes in
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(load_item(i, $urandom_range(0, 1), draw_length(LEN_SHORT)));

        // directed record: padding, numeric zero, skip, full-length padding
        configure_count(4);
        send_item(load_item(0, 1, 4));
        send_item(load_item(1, 0, 2));
        send_item(load_item(2, 0, 0));
        send_item(load_item(3, 1, 255));
        send_item(byte_item(8'd65));
        send_item(load_item(0, 1, 1));    // applies from the next record
        send_item(byte_item(8'd0));
        send_item(byte_item(8'd0));
        send_item(byte_item(8'd255));
        send_item(byte_item(8'd0));
        send_item(byte_item(8'h80));
        send_item(byte_item(8'd1));
        send_item(byte_item(8'd0));
        send_item(byte_item(8'd7));
        send_item(byte_item(8'd0));
        // record of zero-length fields only drops its bytes
        configure_count(2);
        send_item(load_item(0, 0, 0));
        send_item(load_item(1, 1, 0));
        send_item(byte_item(8'd9));
        send_item(byte_item(8'd0));
        send_item(load_item(1, 1, 1));
        send_item(byte_item(8'd0));
        send_item(byte_item(8'h5a));

        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0:       cnt = 1;
                1:       cnt = 64;
                2:       cnt = 0;
                3:       cnt = 127;
                default: cnt = $urandom_range(0, 127);
            endcase
            configure_count(tfd_pkg::CNT_W'(cnt));
            n       = (cnt < 1) ? 1 : (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
            mode    = ph % 3;
            tx_gaps = (ph % 4 != 1);
            rx_gaps = (ph % 4 != 2);
            for (int i = 0; i < n; i++)
                send_item(load_item(i, $urandom_range(0, 1), draw_length(mode)));
            for (int i = 0; i < 96; i++) begin
                if (ph == 5 && i == 48) wait_drained();
                if ($urandom_range(0, 9) == 0) begin
                    idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, n - 1);
                    send_item(load_item(idx, $urandom_range(0, 1), draw_length(mode)));
                end else begin
                    b = ($urandom_range(0, 3) == 0) ? 8'd0
                                                    : 8'($urandom_range(0, 255));
                    send_item(byte_item(b));
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_outputs.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout at %0t", $time);
        $display("status: fail");
        $finish;
    end

endmodule
